// ----- sv/glmf_pkg.sv -----
package glmf_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 9'd256;

  localparam int PEAK_W  = 8;
  localparam int Q_DEPTH = 8;

  typedef struct packed {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
    logic              last;
  } peak_t;

  typedef struct packed {
    logic  en0;
    logic  en1;
    peak_t w0;
    peak_t w1;
  } push_t;

endpackage

// ----- sv/glmf_if.sv -----
interface glmf_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface glmf_peak_if;
  import glmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] peak_row;
  logic [PEAK_W-1:0] peak_col;
  logic              last;

  modport source (output valid, output peak_row, output peak_col, output last, input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last, output ready);
endinterface

// ----- sv/grid_local_maximum_finder_unit.sv -----
// Streaming 4-connected peak finder. Samples enter in raster order, one word per cycle at
// full rate while input ready is high; each accepted sample is judged in the next cycle, and
// its peaks go out in groups of up to two words, the last one flagged (a third waits for the
// next group), through an 8-word result queue. Input ready drops only while that queue
// cannot take two more words for every sample in flight. The result port moves one word per
// cycle, so with a draining sink the input runs at one sample per cycle while samples
// average at most one peak each; a run of two-peak samples, which only the last row of a
// grid can produce, fills the queue and then throttles the input. The two line stores are
// single-port-read RAMs read once per sample, one column ahead, with a bypass for a read
// that meets the write of the sample before. The stores need no clearing after reset.
module grid_local_maximum_finder_unit #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  glmf_sample_if.sink                         in_bus,
  glmf_peak_if.source                         out_bus,
  input  logic                                cfg_we,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glmf_pkg::CFG_W-1:0]          cfg_data
);
  import glmf_pkg::*;

  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CPW = $clog2(MAX_COLS);
  localparam int LW  = $clog2(Q_DEPTH + 1);

  logic [CFG_W-1:0] row_count_r;
  logic [CFG_W-1:0] col_count_r;
  logic [RPW-1:0]   last_r_idx;
  logic [CPW-1:0]   last_c_idx;

  logic [RPW-1:0]   r_pos_r;
  logic [CPW-1:0]   c_pos_r;
  logic             acc;
  logic             lr;
  logic             lc;
  logic [RPW-1:0]   r_nxt;
  logic [CPW-1:0]   c_nxt;

  logic                          b_valid_r;
  logic signed [SAMPLE_BITS-1:0] s_b_r;
  logic [RPW-1:0]                r_b_r;
  logic [CPW-1:0]                c_b_r;
  logic                          lr_b_r;
  logic                          lc_b_r;
  logic                          self_b_r;
  logic                          fwd_r;
  logic signed [SAMPLE_BITS-1:0] fwd_new_r;
  logic signed [SAMPLE_BITS-1:0] fwd_old_r;

  logic signed [SAMPLE_BITS-1:0] cn_r;
  logic signed [SAMPLE_BITS-1:0] co_r;
  logic signed [SAMPLE_BITS-1:0] hl_r;
  logic signed [SAMPLE_BITS-1:0] p1_r;
  logic signed [SAMPLE_BITS-1:0] p2_r;

  logic [SAMPLE_BITS-1:0]        rd_new;
  logic [SAMPLE_BITS-1:0]        rd_old;
  logic signed [SAMPLE_BITS-1:0] nb_new;
  logic signed [SAMPLE_BITS-1:0] nb_old;

  logic             r_ge1;
  logic             r_ge2;
  logic             c_ge1;
  logic             c_ge2;
  logic             up_ok;
  logic             left_ok;
  logic             fin_ok;
  logic             cand_v [4];
  peak_t            cand   [4];
  logic [2:0]       pos;

  logic             pend_v_r;
  logic             pend_v_nxt;
  peak_t            pend_r;
  peak_t            pend_nxt;
  push_t            push;

  peak_t            q_head;
  logic             q_nonempty;
  logic [LW-1:0]    q_level;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= COUNT_RESET;
      col_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_data;
        CFG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_count_r == '0) begin
      last_r_idx = '0;
    end else if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      last_r_idx = RPW'(MAX_ROWS - 1);
    end else begin
      last_r_idx = RPW'(32'(row_count_r) - 32'd1);
    end
    if (col_count_r == '0) begin
      last_c_idx = '0;
    end else if (32'(col_count_r) > 32'(MAX_COLS)) begin
      last_c_idx = CPW'(MAX_COLS - 1);
    end else begin
      last_c_idx = CPW'(32'(col_count_r) - 32'd1);
    end
  end

  assign acc = in_bus.valid & in_bus.ready;
  assign lr  = (r_pos_r >= last_r_idx);
  assign lc  = (c_pos_r >= last_c_idx);

  always_comb begin
    if (lc) begin
      c_nxt = '0;
      r_nxt = lr ? '0 : r_pos_r + RPW'(1);
    end else begin
      c_nxt = c_pos_r + CPW'(1);
      r_nxt = r_pos_r;
    end
  end

  assign in_bus.ready = (32'(q_level) + (b_valid_r ? 32'd2 : 32'd0) + 32'd2) <= 32'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_pos_r   <= '0;
      c_pos_r   <= '0;
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      b_valid_r <= acc;
      fwd_r     <= acc && b_valid_r && (c_nxt == c_b_r);
      pend_v_r  <= pend_v_nxt;
      if (acc) begin
        r_pos_r <= r_nxt;
        c_pos_r <= c_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_b_r    <= SAMPLE_BITS'(in_bus.sample);
      r_b_r    <= r_pos_r;
      c_b_r    <= c_pos_r;
      lr_b_r   <= lr;
      lc_b_r   <= lc;
      self_b_r <= (c_nxt == c_pos_r);
    end
    fwd_new_r <= s_b_r;
    fwd_old_r <= cn_r;
    pend_r    <= pend_nxt;
    if (b_valid_r) begin
      cn_r <= self_b_r ? s_b_r : nb_new;
      co_r <= self_b_r ? cn_r : nb_old;
      hl_r <= cn_r;
      p1_r <= s_b_r;
      p2_r <= p1_r;
    end
  end

  glmf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_newer (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (c_b_r),
    .wdata (s_b_r),
    .re    (acc),
    .raddr (c_nxt),
    .rdata (rd_new)
  );

  glmf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_older (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (c_b_r),
    .wdata (cn_r),
    .re    (acc),
    .raddr (c_nxt),
    .rdata (rd_old)
  );

  always_comb begin
    nb_new  = fwd_r ? fwd_new_r : rd_new;
    nb_old  = fwd_r ? fwd_old_r : rd_old;
    r_ge1   = (r_b_r != '0);
    r_ge2   = (r_b_r > RPW'(1));
    c_ge1   = (c_b_r != '0);
    c_ge2   = (c_b_r > CPW'(1));
    up_ok   = r_ge1 && (s_b_r <= cn_r) && !(r_ge2 && (co_r > cn_r)) &&
              !(c_ge1 && (hl_r > cn_r)) && !(!lc_b_r && (nb_new > cn_r));
    left_ok = lr_b_r && c_ge1 && (s_b_r <= p1_r) && !(c_ge2 && (p2_r > p1_r)) &&
              !(r_ge1 && (hl_r > p1_r));
    fin_ok  = lr_b_r && lc_b_r && !(c_ge1 && (p1_r > s_b_r)) && !(r_ge1 && (cn_r > s_b_r));
  end

  always_comb begin
    cand_v[0] = b_valid_r && pend_v_r;
    cand_v[1] = b_valid_r && up_ok;
    cand_v[2] = b_valid_r && left_ok;
    cand_v[3] = b_valid_r && fin_ok;
    cand[0]   = pend_r;
    cand[1]   = '{row: PEAK_W'(r_b_r - RPW'(1)), col: PEAK_W'(c_b_r), last: 1'b0};
    cand[2]   = '{row: PEAK_W'(r_b_r), col: PEAK_W'(c_b_r - CPW'(1)), last: 1'b0};
    cand[3]   = '{row: PEAK_W'(r_b_r), col: PEAK_W'(c_b_r), last: 1'b0};
  end

  always_comb begin
    pos      = '0;
    push     = '0;
    pend_nxt = pend_r;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        if (pos == 3'd0) begin
          push.w0 = cand[k];
        end else if (pos == 3'd1) begin
          push.w1 = cand[k];
        end else if (pos == 3'd2) begin
          pend_nxt = cand[k];
        end
        pos = pos + 3'd1;
      end
    end
    push.en0     = (pos >= 3'd1);
    push.en1     = (pos >= 3'd2);
    push.w0.last = (pos == 3'd1);
    push.w1.last = 1'b1;
    pend_v_nxt   = b_valid_r ? (pos > 3'd2) : pend_v_r;
  end

  assign pop = out_bus.valid & out_bus.ready;

  glmf_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (q_head),
    .nonempty (q_nonempty),
    .level    (q_level)
  );

  assign out_bus.valid    = q_nonempty;
  assign out_bus.peak_row = q_head.row;
  assign out_bus.peak_col = q_head.col;
  assign out_bus.last     = q_head.last;

endmodule

// ----- sv/glmf_ram.sv -----
module glmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- sv/glmf_queue.sv -----
module glmf_queue #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  glmf_pkg::push_t            push,
  input  logic                       pop,
  output glmf_pkg::peak_t            head,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import glmf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  peak_t          mem_r [DEPTH];
  logic [AW-1:0]  head_r;
  logic [AW-1:0]  tail_r;
  logic [LW-1:0]  level_r;
  logic [AW-1:0]  tail_1;
  logic [AW-1:0]  tail_nxt;
  logic [LW-1:0]  level_nxt;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    if (p == AW'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + AW'(1);
    end
    return q;
  endfunction

  always_comb begin
    tail_1 = inc(tail_r);
    if (push.en1) begin
      tail_nxt = inc(tail_1);
    end else if (push.en0) begin
      tail_nxt = tail_1;
    end else begin
      tail_nxt = tail_r;
    end
    level_nxt = level_r + LW'(push.en0) + LW'(push.en1) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.en0) begin
      mem_r[tail_r] <= push.w0;
    end
    if (push.en1) begin
      mem_r[tail_1] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
      if (pop) begin
        head_r <= inc(head_r);
      end
    end
  end

  assign head     = mem_r[head_r];
  assign nonempty = (level_r != '0);
  assign level    = level_r;

endmodule

// ----- sv/glmf_checker.sv -----
module glmf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [glmf_pkg::PEAK_W-1:0] out_row,
  input logic [glmf_pkg::PEAK_W-1:0] out_col,
  input logic                        out_last
);
  import glmf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_row, out_col, out_last}))
    else $error("result word changed or dropped while stalled");

  a_group_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("word without last was not followed by the rest of its group");

  a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result word waiting");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word appeared without a sample two cycles earlier");

endmodule

bind grid_local_maximum_finder_unit glmf_checker u_glmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_row   (out_bus.peak_row),
  .out_col   (out_bus.peak_col),
  .out_last  (out_bus.last)
);
